// File: sv/hcls_pkg.sv
// ----------------------------------------------------------------------------
// hcls_pkg
// Types, codes and name tables shared by the Content-Length scanner files.
// ----------------------------------------------------------------------------
package hcls_pkg;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last;
    } t_hcls_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        length_found;
        logic [31:0] body_length;
    } t_hcls_out;

    // status codes; ST_NONE marks an outcome not yet decided
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_BIG  = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    localparam logic [31:0] UPLOAD_LIMIT_RST = 32'd33554432;

    localparam logic [4:0] CL_LEN   = 5'd14;
    localparam logic [4:0] TE_LEN   = 5'd17;
    localparam logic [4:0] NAME_MAX = 5'd31;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [5:0] {
        PH_REQ    = 6'b000001,
        PH_NAME   = 6'b000010,
        PH_SKIP   = 6'b000100,
        PH_LEAD   = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_TRAIL  = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  cnt;
        logic        cl_m;
        logic        te_m;
        logic        fault;
        logic        ovf;
        logic [31:0] acc;
    } t_line;

    localparam t_line LINE_CLEAR = '{PH_REQ, 5'd0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0};
    localparam t_line LINE_NEW   = '{PH_NAME, 5'd0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0};

    // lower-case "content-length"
    function automatic logic [7:0] f_cl_char(logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = "c";
            5'd1:    ch = "o";
            5'd2:    ch = "n";
            5'd3:    ch = "t";
            5'd4:    ch = "e";
            5'd5:    ch = "n";
            5'd6:    ch = "t";
            5'd7:    ch = "-";
            5'd8:    ch = "l";
            5'd9:    ch = "e";
            5'd10:   ch = "n";
            5'd11:   ch = "g";
            5'd12:   ch = "t";
            5'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // lower-case "transfer-encoding"
    function automatic logic [7:0] f_te_char(logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = "t";
            5'd1:    ch = "r";
            5'd2:    ch = "a";
            5'd3:    ch = "n";
            5'd4:    ch = "s";
            5'd5:    ch = "f";
            5'd6:    ch = "e";
            5'd7:    ch = "r";
            5'd8:    ch = "-";
            5'd9:    ch = "e";
            5'd10:   ch = "n";
            5'd11:   ch = "c";
            5'd12:   ch = "o";
            5'd13:   ch = "d";
            5'd14:   ch = "i";
            5'd15:   ch = "n";
            5'd16:   ch = "g";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: sv/http_content_length_scanner_core.sv
// A result is registered in the result register, or in its skid stage while the output is stalled.
// Throughput: one header byte per cycle while the input is not stalled; the per-byte update is a single register pass.
// Input stalls only when both the result register and its skid stage hold results.
// Reset (synchronous, active low) clears the parser to the request line, empties the
// output stages and sets upload_limit to 32 MiB.
// ----------------------------------------------------------------------------
// http_content_length_scanner_core
// Scans HTTP header text and reports the Content-Length it declares.
// ----------------------------------------------------------------------------
module http_content_length_scanner_core
    import hcls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_hcls_in    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_hcls_out   o_out_data,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    logic      accept;
    logic      res_valid;
    t_hcls_out res_data;
    logic      buf_full;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    hcls_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res_valid   (res_valid),
        .o_res_data    (res_data)
    );

    hcls_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_data (res_data),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sv/hcls_parser.sv
// ----------------------------------------------------------------------------
// hcls_parser
// Per-byte line state, header name match, length accumulation and outcome.
// ----------------------------------------------------------------------------
module hcls_parser
    import hcls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_hcls_in    i_in_data,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    output logic        o_res_valid,
    output t_hcls_out   o_res_data
);

    t_line       r_line, n_line;
    logic        r_held, n_held;
    logic        r_found, n_found;
    logic [31:0] r_len, n_len;
    logic [1:0]  r_dec, n_dec;
    logic [31:0] r_limit;
    logic [1:0]  res_status;

    function automatic t_line f_fault(t_line s);
        t_line r;
        r       = s;
        r.fault = 1'b1;
        r.phase = PH_SKIP;
        return r;
    endfunction

    // a CR that turned out not to start a line end
    function automatic t_line f_take_cr(t_line s);
        t_line r;
        r = s;
        case (s.phase)
            PH_NAME: begin
                if (s.cnt < CL_LEN) r.cl_m = 1'b0;
                if (s.cnt < TE_LEN) r.te_m = 1'b0;
                if (s.cnt < NAME_MAX) r.cnt = s.cnt + 5'd1;
            end
            PH_LEAD, PH_DIGITS, PH_TRAIL: begin
                r = f_fault(s);
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

    function automatic t_line f_take(t_line s, logic [7:0] c, logic found,
                                     logic [31:0] limit);
        t_line       r;
        logic [7:0]  low;
        logic [35:0] prod;
        logic        digit;
        logic        blank;
        r     = s;
        low   = (c inside {[8'h41:8'h5A]}) ? c + 8'h20 : c;
        digit = c inside {[8'h30:8'h39]};
        blank = (c == CH_SPACE) || (c == CH_TAB);
        prod  = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {32'd0, c[3:0]};
        case (s.phase)
            PH_NAME: begin
                if (c == CH_COLON) begin
                    if (s.cnt == CL_LEN && s.cl_m) begin
                        if (found) r = f_fault(s);
                        else       r.phase = PH_LEAD;
                    end else begin
                        r.phase = PH_SKIP;
                    end
                end else begin
                    if (s.cnt < CL_LEN && low != f_cl_char(s.cnt)) r.cl_m = 1'b0;
                    if (s.cnt < TE_LEN && low != f_te_char(s.cnt)) r.te_m = 1'b0;
                    if (s.cnt < NAME_MAX) r.cnt = s.cnt + 5'd1;
                end
            end
            PH_LEAD, PH_DIGITS: begin
                if (digit) begin
                    r.phase = PH_DIGITS;
                    r.acc   = prod[31:0];
                    if (prod > {4'd0, limit}) begin
                        r.ovf   = 1'b1;
                        r.phase = PH_SKIP;
                    end
                end else if (blank) begin
                    if (s.phase == PH_DIGITS) r.phase = PH_TRAIL;
                end else begin
                    r = f_fault(s);
                end
            end
            PH_TRAIL: begin
                if (!blank) r = f_fault(s);
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

    always_comb begin
        n_line = r_line;
        n_held = r_held;
        n_found = r_found;
        n_len = r_len;
        n_dec = r_dec;
        if (r_dec == ST_NONE) begin
            if (r_held) begin
                n_held = 1'b0;
                if (i_in_data.header_byte == CH_LF) begin
                    // line end: settle the finished line
                    case (r_line.phase)
                        PH_REQ: begin
                            n_line = LINE_NEW;
                        end
                        PH_NAME: begin
                            n_dec = (r_line.cnt == 5'd0) ? ST_OK : ST_BAD;
                        end
                        PH_SKIP: begin
                            if (r_line.ovf)                                n_dec = ST_BIG;
                            else if (r_line.fault)                         n_dec = ST_BAD;
                            else if (r_line.cnt == TE_LEN && r_line.te_m)  n_dec = ST_BAD;
                            else                                           n_line = LINE_NEW;
                        end
                        PH_LEAD: begin
                            n_dec = ST_BAD;
                        end
                        default: begin
                            n_found = 1'b1;
                            n_len   = r_line.acc;
                            n_line  = LINE_NEW;
                        end
                    endcase
                end else begin
                    n_line = f_take_cr(r_line);
                    if (i_in_data.header_byte == CH_CR) n_held = 1'b1;
                    else n_line = f_take(n_line, i_in_data.header_byte, r_found, r_limit);
                end
            end else if (i_in_data.header_byte == CH_CR) begin
                n_held = 1'b1;
            end else begin
                n_line = f_take(r_line, i_in_data.header_byte, r_found, r_limit);
            end
        end
    end

    always_comb begin
        if (n_dec != ST_NONE)                                     res_status = n_dec;
        else if (n_line.phase == PH_NAME && n_line.cnt == 5'd0 && !n_held) res_status = ST_OK;
        else                                                      res_status = ST_BAD;
    end

    assign o_res_valid                = i_accept && i_in_data.last;
    assign o_res_data.status          = res_status;
    assign o_res_data.length_found    = (res_status == ST_OK) && n_found;
    assign o_res_data.body_length     = ((res_status == ST_OK) && n_found) ? n_len : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= LINE_CLEAR;
            r_held  <= 1'b0;
            r_found <= 1'b0;
            r_len   <= 32'd0;
            r_dec   <= ST_NONE;
            r_limit <= UPLOAD_LIMIT_RST;
        end else begin
            if (i_cfg_wr_en) r_limit <= i_cfg_wr_data;
            if (i_accept) begin
                if (i_in_data.last) begin
                    // header block done: start over
                    r_line  <= LINE_CLEAR;
                    r_held  <= 1'b0;
                    r_found <= 1'b0;
                    r_len   <= 32'd0;
                    r_dec   <= ST_NONE;
                end else begin
                    r_line  <= n_line;
                    r_held  <= n_held;
                    r_found <= n_found;
                    r_len   <= n_len;
                    r_dec   <= n_dec;
                end
            end
        end
    end

endmodule

// File: sv/hcls_out_buf.sv
// ----------------------------------------------------------------------------
// hcls_out_buf
// Result register with a skid stage so input keeps flowing under stall.
// ----------------------------------------------------------------------------
module hcls_out_buf
    import hcls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_hcls_out i_push_data,
    output logic      o_full,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_hcls_out o_out_data
);

    logic      r_out_valid;
    t_hcls_out r_out;
    logic      r_skid_valid;
    t_hcls_out r_skid;
    logic      out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // drain skid first; no push can arrive while it is full
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_push_data;
        end else if (i_push) begin
            r_skid <= i_push_data;
        end
    end

endmodule

// File: sv/hcls_checker.sv
// ----------------------------------------------------------------------------
// hcls_checker
// Port-level checks on result transactions of the scanner core.
// ----------------------------------------------------------------------------
module hcls_checker
    import hcls_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input t_hcls_in  i_in_data,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_hcls_out i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result transaction changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.status != ST_NONE)
        else $error("undecided status code on output");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != ST_OK || !i_out_data.length_found)
        |-> !i_out_data.length_found && i_out_data.body_length == 32'd0)
        else $error("length reported without an accepted Content-Length");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && !i_in_stall && i_in_data.last))
        else $error("result without a last-byte transaction");

endmodule

bind http_content_length_scanner_core hcls_checker u_hcls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

// File: tb/http_content_length_scanner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_content_length_scanner_core_tb
// Feeds header texts byte by byte: directed corner cases first, then random
// requests and noise under several stall mixes and upload limits, with one
// long output hold-off. Every result is checked against a scanner model.
// ----------------------------------------------------------------------------
module http_content_length_scanner_core_tb;
    import hcls_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_hcls_in    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_hcls_out   o_out_data;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;

    http_content_length_scanner_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    string       cl_name = "content-length";
    string       te_name = "transfer-encoding";
    logic [31:0] size_cap = UPLOAD_LIMIT_RST;
    t_phase      ln_phase;
    logic        pend_cr;
    logic [4:0]  nm_cnt;
    logic        cl_hit;
    logic        te_hit;
    logic        ln_bad;
    logic        ln_big;
    logic [35:0] acc;
    logic        cl_seen;
    logic [31:0] cl_value;
    logic [1:0]  verdict;

    t_hcls_out   due_report_q[$];
    t_hcls_in    byte_q[$];
    logic [7:0]  text_q[$];
    t_hcls_out   want;

    int accepted_n = 0;
    int presented_n = 0;
    int sent_bytes = 0;
    int err_cnt = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int hold_len = 0;

    function void start_line();
        ln_phase = PH_NAME;
        nm_cnt   = 5'd0;
        cl_hit   = 1'b1;
        te_hit   = 1'b1;
        ln_bad   = 1'b0;
        ln_big   = 1'b0;
        acc      = 36'd0;
    endfunction

    function void clear_scan();
        start_line();
        ln_phase = PH_REQ;
        pend_cr  = 1'b0;
        cl_seen  = 1'b0;
        cl_value = 32'd0;
        verdict  = ST_NONE;
    endfunction

    function void fail_line();
        ln_bad   = 1'b1;
        ln_phase = PH_SKIP;
    endfunction

    function logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function void close_line();
        case (ln_phase)
            PH_REQ: start_line();
            PH_NAME: verdict = (nm_cnt == 5'd0) ? ST_OK : ST_BAD;
            PH_SKIP: begin
                if (ln_big)
                    verdict = ST_BIG;
                else if (ln_bad)
                    verdict = ST_BAD;
                else if (nm_cnt == TE_LEN && te_hit)
                    verdict = ST_BAD;
                else
                    start_line();
            end
            PH_LEAD: verdict = ST_BAD;
            default: begin
                cl_seen  = 1'b1;
                cl_value = acc[31:0];
                start_line();
            end
        endcase
    endfunction

    function void take_char(logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        case (ln_phase)
            PH_NAME: begin
                if (c == CH_COLON) begin
                    if (nm_cnt == CL_LEN && cl_hit) begin
                        if (cl_seen)
                            fail_line();
                        else
                            ln_phase = PH_LEAD;
                    end else begin
                        ln_phase = PH_SKIP;
                    end
                end else begin
                    if (nm_cnt < CL_LEN && lc != cl_name[nm_cnt])
                        cl_hit = 1'b0;
                    if (nm_cnt < TE_LEN && lc != te_name[nm_cnt])
                        te_hit = 1'b0;
                    if (nm_cnt < NAME_MAX)
                        nm_cnt = nm_cnt + 5'd1;
                end
            end
            PH_LEAD, PH_DIGITS: begin
                if (c >= "0" && c <= "9") begin
                    ln_phase = PH_DIGITS;
                    acc = acc * 36'd10 + {28'd0, c - 8'h30};
                    // too large wins at this line's CRLF
                    if (acc > {4'd0, size_cap}) begin
                        ln_big   = 1'b1;
                        ln_phase = PH_SKIP;
                    end
                end else if (is_blank(c)) begin
                    if (ln_phase == PH_DIGITS)
                        ln_phase = PH_TRAIL;
                end else begin
                    fail_line();
                end
            end
            PH_TRAIL: begin
                if (!is_blank(c))
                    fail_line();
            end
            default: ;
        endcase
    endfunction

    function void scan_byte(t_hcls_in it);
        t_hcls_out  rpt;
        logic [7:0] c;
        c = it.header_byte;
        if (verdict == ST_NONE) begin
            if (pend_cr) begin
                pend_cr = 1'b0;
                if (c == CH_LF) begin
                    close_line();
                end else begin
                    // a lone CR is plain line text
                    take_char(CH_CR);
                    if (c == CH_CR)
                        pend_cr = 1'b1;
                    else
                        take_char(c);
                end
            end else if (c == CH_CR) begin
                pend_cr = 1'b1;
            end else begin
                take_char(c);
            end
        end
        if (it.last) begin
            if (verdict != ST_NONE)
                rpt.status = verdict;
            else if (ln_phase == PH_NAME && nm_cnt == 5'd0 && !pend_cr)
                rpt.status = ST_OK;
            else
                rpt.status = ST_BAD;
            rpt.length_found = (rpt.status == ST_OK) && cl_seen;
            rpt.body_length  = rpt.length_found ? cl_value : 32'd0;
            due_report_q.push_back(rpt);
            clear_scan();
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver, acceptance, monitor, output stall
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && accepted_n != presented_n) begin
            // hold the stalled transaction
        end else if (byte_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
            i_in_data  <= byte_q.pop_front();
            i_in_valid <= 1'b1;
            presented_n++;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            scan_byte(i_in_data);
            accepted_n++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_report_q.size() == 0) begin
                $error("unexpected result: status %0d length_found %0d body_length %0d",
                       o_out_data.status, o_out_data.length_found, o_out_data.body_length);
                err_cnt++;
            end else begin
                want = due_report_q.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    err_cnt++;
                end
                if (o_out_data.length_found !== want.length_found) begin
                    $error("length_found: expected %0d, got %0d",
                           want.length_found, o_out_data.length_found);
                    err_cnt++;
                end
                if (o_out_data.body_length !== want.body_length) begin
                    $error("body_length: expected %0d, got %0d",
                           want.body_length, o_out_data.body_length);
                    err_cnt++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_left = hold_len - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Text builders
    // ------------------------------------------------------------------
    task automatic put_byte(logic [7:0] b);
        text_q.push_back(b);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic put_crlf();
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
    endtask

    task automatic put_line(string s);
        put_str(s);
        put_crlf();
    endtask

    // random letter case on the header name
    task automatic put_name(string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(1) == 1)
                c = c - 8'd32;
            text_q.push_back(c);
        end
    endtask

    task automatic put_letters(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(27);
            if (r < 26)
                text_q.push_back(8'h61 + r[7:0]);
            else if (r == 26)
                text_q.push_back("-");
            else
                text_q.push_back("Z");
        end
    endtask

    task automatic put_printable(int n);
        for (int i = 0; i < n; i++)
            text_q.push_back(8'($urandom_range(32, 126)));
    endtask

    task automatic put_blanks(int n);
        for (int i = 0; i < n; i++)
            text_q.push_back(($urandom_range(1) == 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic put_noise(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(7) == 0)
                put_crlf();
            else
                text_q.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_text();
        t_hcls_in it;
        for (int i = 0; i < text_q.size(); i++) begin
            it.header_byte = text_q[i];
            it.last        = (i == text_q.size() - 1);
            byte_q.push_back(it);
        end
        sent_bytes += text_q.size();
        text_q.delete();
    endtask

    task automatic put_number();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = 64'($urandom_range(999));
            1: v = 64'($urandom);
            2: begin
                // straddle the current limit
                v = {32'd0, size_cap};
                case ($urandom_range(2))
                    0: if (v != 64'd0) v = v - 64'd1;
                    1: ;
                    default: v = v + 64'd1;
                endcase
            end
            3: v = {$urandom, $urandom} % 64'd100_000_000_000_000;
            4: begin
                put_str("000");
                v = 64'($urandom_range(99));
            end
            default: v = 64'd0;
        endcase
        put_str($sformatf("%0d", v));
    endtask

    task automatic put_length_line();
        int form;
        put_name("content-length");
        put_byte(CH_COLON);
        put_blanks($urandom_range(2));
        form = $urandom_range(11);
        if (form != 0)
            put_number();
        if (form == 1) begin
            put_printable(1);
        end else if (form == 2) begin
            put_blanks(1);
            put_str("x");
        end
        put_blanks($urandom_range(2));
        put_crlf();
    endtask

    task automatic put_near_name();
        case ($urandom_range(4))
            0: put_name("content-lengt");
            1: put_name("content-lengthx");
            2: put_name("transfer-encodin");
            3: put_name("transfer-encodings");
            default: put_letters(32 + $urandom_range(8));
        endcase
        put_byte(CH_COLON);
        put_line(" 12");
    endtask

    task automatic make_request();
        int kind;
        int tail;
        case ($urandom_range(2))
            0: put_str("GET /");
            1: put_str("POST /");
            default: put_str("PUT /");
        endcase
        put_printable($urandom_range(4));
        if ($urandom_range(19) != 0) begin
            put_crlf();
            for (int i = 0; i < $urandom_range(3); i++) begin
                kind = $urandom_range(99);
                if (kind < 35) begin
                    put_length_line();
                end else if (kind < 45) begin
                    put_name("transfer-encoding");
                    put_line(": chunked");
                end else if (kind < 58) begin
                    put_near_name();
                end else if (kind < 64) begin
                    put_letters($urandom_range(1, 8));
                    put_crlf();
                end else if (kind < 70) begin
                    put_str("X-Raw: a");
                    put_byte(CH_LF);
                    put_str("b");
                    put_byte(CH_CR);
                    put_line("c");
                end else begin
                    put_letters($urandom_range(1, 10));
                    put_byte(CH_COLON);
                    put_printable($urandom_range(8));
                    put_crlf();
                end
            end
            tail = $urandom_range(99);
            if (tail < 72) begin
                put_crlf();
                if ($urandom_range(3) == 0)
                    put_noise($urandom_range(1, 5));
            end else if (tail >= 91) begin
                put_byte(CH_CR);
            end else if (tail >= 82) begin
                put_str("X-Cut: q");
            end
        end
        send_text();
    endtask

    // ------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------
    task automatic finish_phase();
        while (byte_q.size() != 0 || accepted_n != presented_n || due_report_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [31:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        size_cap = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(int budget);
        int stop_at;
        stop_at = sent_bytes + budget;
        while (sent_bytes < stop_at) begin
            if ($urandom_range(3) == 0) begin
                put_noise($urandom_range(1, 12));
                send_text();
            end else begin
                make_request();
            end
        end
        finish_phase();
    endtask

    task automatic run_directed();
        put_line("GET / HTTP/1.1"); put_line("Host: a"); put_line("Content-Length: 42");
        put_crlf(); send_text();
        put_str("GET /"); send_text();
        put_crlf(); send_text();
        put_byte(CH_CR); send_text();
        put_str("A"); send_text();
        put_line("G"); put_str("Host: x"); send_text();
        put_line("G"); put_str("Host: x"); put_byte(CH_CR); send_text();
        put_line("G"); put_line("Host: x"); send_text();
        // lone LF and CR in text, then CR CR LF
        put_str("G"); put_byte(CH_LF); put_str("x"); put_byte(CH_CR); put_line("y");
        put_str("X-V: a"); put_byte(CH_CR); put_crlf();
        put_str("cOnTeNt-LeNgTh:"); put_byte(CH_TAB); put_str("7"); put_byte(CH_TAB);
        put_crlf(); put_crlf(); send_text();
        put_line("G"); put_line("Host"); put_crlf(); send_text();
        put_line("G"); put_line("Content-Length:  "); put_crlf(); send_text();
        put_line("G"); put_line("Content-Length: 1"); put_line("content-length: 1");
        put_crlf(); send_text();
        put_line("G"); put_line("Content-Length: 12a"); put_crlf(); send_text();
        put_line("G"); put_line("Content-Length: 12 x"); put_crlf(); send_text();
        put_line("G"); put_line("Transfer-Encoding: chunked"); put_crlf(); send_text();
        put_line("G"); put_line("transfer-encodings: x"); put_line("content-lengthx: 5");
        put_crlf(); send_text();
        put_line("G"); put_line("Content-Length: 33554432"); put_crlf(); send_text();
        put_line("G"); put_line("Content-Length: 33554433"); put_crlf(); send_text();
        put_line("G"); put_str("Content-Length: 99999999999"); send_text();
        put_line("G"); put_line("Content-Length: x99999999999"); put_crlf(); send_text();
        put_line("G"); put_line("Content-Length: 99999999999zz"); put_crlf(); send_text();
        put_line("G"); put_line("Host"); put_line("Content-Length: 99999999999");
        put_crlf(); send_text();
        put_line("G"); put_letters(40); put_byte(CH_COLON);
        put_byte(8'hFF); put_byte(8'h80); put_byte(8'h7F); put_crlf(); put_crlf(); send_text();
        put_line("G"); put_line("Content-Length: 0"); put_crlf();
        put_str("xyz"); put_byte(8'hFF); put_byte(CH_CR); send_text();
        put_line("G"); put_line("Content-Length: 0000000000000000000005"); put_crlf();
        send_text();
        put_line("G"); put_line("Content-Length:5"); put_line("Transfer-Encoding");
        put_crlf(); send_text();
        finish_phase();
    endtask

    initial begin
        #2000000;
        $display("FAIL http_content_length_scanner_core");
        $finish;
    end

    initial begin
        clear_scan();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        set_limit(32'hFFFF_FFFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(170);

        set_limit(32'd0);
        tx_idle_pct = 81;
        rx_idle_pct = 0;
        run_random(170);

        set_limit($urandom);
        tx_idle_pct = 0;
        rx_idle_pct = 81;
        run_random(170);

        set_limit(32'd1000);
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        run_random(170);

        // hold the output off while short texts keep arriving
        set_limit(UPLOAD_LIMIT_RST);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_len = 300;
        hold_req++;
        @(negedge i_clk);
        for (int i = 0; i < 40; i++) begin
            case ($urandom_range(2))
                0: put_crlf();
                1: put_line("A");
                default: put_noise($urandom_range(1, 3));
            endcase
            send_text();
        end
        finish_phase();

        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("PASS http_content_length_scanner_core");
        else
            $display("FAIL http_content_length_scanner_core");
        $finish;
    end

endmodule
